>>> src/ffu_pkg.sv
// Shared types, constants and helper functions of the fire field engine.
`default_nettype none

package ffu_pkg;

    // Field and register widths
    localparam int CMD_W     = 2;
    localparam int POS_W     = 8;
    localparam int HEAT_W    = 16;
    localparam int DIM_W     = 9;
    localparam int COOL_W    = 16;
    localparam int GAIN_W    = 15;
    localparam int REACH_W   = 4;
    localparam int RSQ_W     = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;
    localparam int RNG_W     = 32;
    // Column carried with a burner beat: wide enough for 1024 columns
    localparam int COORD_W   = 10;

    // Commands
    localparam logic [CMD_W-1:0] CMD_FRAME = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FIRE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COOLING     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BURNER_ON   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BURNER_GAIN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FB_REACH    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FB_RSQ      = 3'd6;

    // Register reset values
    localparam logic [DIM_W-1:0]   RST_GRID_WIDTH  = 9'd256;
    localparam logic [DIM_W-1:0]   RST_GRID_HEIGHT = 9'd256;
    localparam logic [COOL_W-1:0]  RST_COOLING     = 16'd922;
    localparam logic               RST_BURNER_ON   = 1'b1;
    localparam logic [GAIN_W-1:0]  RST_BURNER_GAIN = 15'd16384;
    localparam logic [REACH_W-1:0] RST_FB_REACH    = 4'd11;
    localparam logic [RSQ_W-1:0]   RST_FB_RSQ      = 8'd111;

    localparam logic [HEAT_W-1:0] FULL_HEAT = 16'hffff;
    localparam logic [RNG_W-1:0]  RNG_SEED  = 32'h2545f491;
    localparam int MIN_DIM = 8;

    // Burner: 0.88 and 0.12 of full heat, truncated
    localparam logic [15:0] BURN_BASE = 16'd57671;
    localparam logic [12:0] BURN_SPAN = 13'd7864;
    localparam int          BURN_U_W  = 24;
    localparam int          GAIN_FRAC = 14;

    typedef struct packed {
        logic               valid;
        logic               on;
        logic [COORD_W-1:0] x;
        logic [RNG_W-1:0]   r;
    } t_burn_in;

    typedef struct packed {
        logic               valid;
        logic               pending;
        logic [COORD_W-1:0] x;
        logic [HEAT_W-1:0]  heat;
    } t_burn_out;

    // xorshift32, shifts 13 / 17 / 5
    function automatic logic [RNG_W-1:0] xorshift32(input logic [RNG_W-1:0] s);
        logic [RNG_W-1:0] t;
        t = s ^ (s << 13);
        t = t ^ (t >> 17);
        t = t ^ (t << 5);
        return t;
    endfunction

    function automatic logic [1:0] mod3_small(input logic [3:0] v);
        logic [1:0] m;
        case (v)
            4'd0, 4'd3, 4'd6, 4'd9, 4'd12, 4'd15: m = 2'd0;
            4'd1, 4'd4, 4'd7, 4'd10, 4'd13:       m = 2'd1;
            default:                              m = 2'd2;
        endcase
        return m;
    endfunction

    // 4 == 1 and 256 == 1 mod 3: fold 2-bit digits per byte, then bytes
    function automatic logic [1:0] mod3_32(input logic [RNG_W-1:0] r);
        logic [3:0] digit_sum;
        logic [3:0] byte_sum;
        byte_sum = 4'd0;
        for (int b = 0; b < 4; b++) begin
            digit_sum = 4'(r[8*b +: 2]) + 4'(r[8*b+2 +: 2])
                      + 4'(r[8*b+4 +: 2]) + 4'(r[8*b+6 +: 2]);
            byte_sum  = byte_sum + 4'(mod3_small(digit_sum));
        end
        return mod3_small(byte_sum);
    endfunction

endpackage

`default_nettype wire

>>> src/ffu_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
`default_nettype none

module ffu_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> src/ffu_burner.sv
// Burner row heat: two-stage pipeline, flare base then gain with saturation.
`default_nettype none

module ffu_burner (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [ffu_pkg::GAIN_W-1:0]    i_gain,
    input  wire ffu_pkg::t_burn_in             i_beat,
    output ffu_pkg::t_burn_out                 o_beat
);
    import ffu_pkg::*;

    localparam int PROD1_W = 13 + BURN_U_W;
    localparam int PROD2_W = HEAT_W + GAIN_W;

    logic                r_s1_valid;
    logic                r_s1_on;
    logic [COORD_W-1:0]  r_s1_x;
    logic [HEAT_W-1:0]   r_s1_base;
    logic                r_s2_valid;
    logic [COORD_W-1:0]  r_s2_x;
    logic [HEAT_W-1:0]   r_s2_heat;

    logic [PROD1_W-1:0]  w_prod1;
    logic [HEAT_W-1:0]   w_base;
    logic [PROD2_W-1:0]  w_prod2;
    logic [HEAT_W:0]     w_scaled;
    logic [HEAT_W-1:0]   w_heat;

    // base = 0.88 + 0.12 * u / 2^24 in heat units
    assign w_prod1 = PROD1_W'(BURN_SPAN) * PROD1_W'(i_beat.r[BURN_U_W-1:0]);
    assign w_base  = BURN_BASE + HEAT_W'(w_prod1[PROD1_W-1:BURN_U_W]);

    assign w_prod2  = PROD2_W'(r_s1_base) * PROD2_W'(i_gain);
    assign w_scaled = w_prod2[PROD2_W-1:GAIN_FRAC];

    always_comb begin
        if (!r_s1_on) begin
            w_heat = '0;
        end else if (w_scaled[HEAT_W]) begin
            w_heat = FULL_HEAT;
        end else begin
            w_heat = w_scaled[HEAT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_beat.valid;
            r_s2_valid <= r_s1_valid;
        end
        r_s1_on   <= i_beat.on;
        r_s1_x    <= i_beat.x;
        r_s1_base <= w_base;
        r_s2_x    <= r_s1_x;
        r_s2_heat <= w_heat;
    end

    assign o_beat.valid   = r_s2_valid;
    assign o_beat.pending = r_s1_valid;
    assign o_beat.x       = r_s2_x;
    assign o_beat.heat    = r_s2_heat;

endmodule

`default_nettype wire

>>> src/fire_field_update_core.sv
// Top level of the fire field engine: sequencer, scatter stage and heat store.
//
//  channel   | signals                                  | handshake
//  ----------+------------------------------------------+------------------------------
//  command   | i_command, i_pos_x, i_pos_y              | start high, busy low
//  result    | o_heat_value, o_done_command             | o_done strobe, one cycle
//  config    | i_cfg_we, i_cfg_index, i_cfg_data        | written when i_cfg_we high
//
//  A frame step moves one cell per cycle through the store's read and write ports.
//  After reset the store is swept to zero, one cell per cycle, with busy high;
//  config writes are taken meanwhile.
//  One command at a time; results cannot be stalled.
`default_nettype none

module fire_field_update_core #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [ffu_pkg::CMD_W-1:0]         i_command,
    input  wire logic [ffu_pkg::POS_W-1:0]         i_pos_x,
    input  wire logic [ffu_pkg::POS_W-1:0]         i_pos_y,
    output logic                                   o_done,
    output logic [ffu_pkg::HEAT_W-1:0]             o_heat_value,
    output logic [ffu_pkg::CMD_W-1:0]              o_done_command,
    input  wire logic                              i_cfg_we,
    input  wire logic [ffu_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [ffu_pkg::CFG_DAT_W-1:0]     i_cfg_data
);
    import ffu_pkg::*;

    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int SW    = 12;   // signed fireball coordinates

    localparam logic [3:0] ST_IDLE        = 4'd0;
    localparam logic [3:0] ST_CLEAR       = 4'd1;
    localparam logic [3:0] ST_FRAME       = 4'd2;
    localparam logic [3:0] ST_FRAME_DRAIN = 4'd3;
    localparam logic [3:0] ST_BURN        = 4'd4;
    localparam logic [3:0] ST_BURN_DRAIN  = 4'd5;
    localparam logic [3:0] ST_FIRE        = 4'd6;
    localparam logic [3:0] ST_READ        = 4'd7;
    localparam logic [3:0] ST_READ_WAIT   = 4'd8;

    // Config registers
    logic [DIM_W-1:0]   r_cfg_width;
    logic [DIM_W-1:0]   r_cfg_height;
    logic [COOL_W-1:0]  r_cfg_cool;
    logic               r_cfg_burner_on;
    logic [GAIN_W-1:0]  r_cfg_gain;
    logic [REACH_W-1:0] r_cfg_reach;
    logic [RSQ_W-1:0]   r_cfg_rsq;

    // Control
    logic [3:0]         r_state,  n_state;
    logic [XW-1:0]      r_x,      n_x;
    logic [YW-1:0]      r_y,      n_y;
    logic [AW-1:0]      r_addr,   n_addr;
    logic [RNG_W-1:0]   r_rng,    n_rng;
    logic               r_report, n_report;
    logic               r_b_valid, n_b_valid;
    logic signed [4:0]  r_dx,     n_dx;
    logic signed [4:0]  r_dy,     n_dy;
    logic [CMD_W-1:0]   r_cmd,    n_cmd;
    logic [POS_W-1:0]   r_px,     n_px;
    logic [POS_W-1:0]   r_py,     n_py;
    logic               r_done,   n_done;
    logic [HEAT_W-1:0]  r_heat,   n_heat;
    logic [CMD_W-1:0]   r_done_cmd, n_done_cmd;

    // Scatter stage payload
    logic [XW-1:0]      r_b_x;
    logic [YW-1:0]      r_b_y;
    logic [RNG_W-1:0]   r_b_r;

    logic [WW-1:0]      w_w;
    logic [HW-1:0]      w_h;
    logic [RNG_W-1:0]   w_draw;
    logic               w_x_last;
    logic               w_y_last;
    logic               w_read_ok;

    logic [1:0]         w_drift;
    logic [WW-1:0]      w_bx_inc;
    logic [XW-1:0]      w_tx;
    logic [HEAT_W-1:0]  w_cooled;

    logic signed [4:0]  w_reach_s;
    logic signed [SW-1:0] w_fx;
    logic signed [SW-1:0] w_fy;
    logic signed [9:0]  w_dx_ext;
    logic signed [9:0]  w_dy_ext;
    logic [9:0]         w_dist_sq;
    logic               w_fire_hit;

    t_burn_in           w_burn_in;
    t_burn_out          w_burn_out;

    logic               w_we;
    logic [AW-1:0]      w_waddr;
    logic [HEAT_W-1:0]  w_wdata;
    logic [AW-1:0]      w_raddr;
    logic [HEAT_W-1:0]  w_rdata;

    function automatic logic [AW-1:0] cell_addr(input logic [XW-1:0] x,
                                                input logic [YW-1:0] y);
        return AW'(AW'(y) * AW'(MAX_WIDTH)) + AW'(x);
    endfunction

    function automatic logic [WW-1:0] clamp_w(input logic [DIM_W-1:0] v);
        logic [WW-1:0] c;
        if (v < DIM_W'(MIN_DIM)) begin
            c = WW'(MIN_DIM);
        end else if (32'(v) > MAX_WIDTH) begin
            c = WW'(MAX_WIDTH);
        end else begin
            c = WW'(v);
        end
        return c;
    endfunction

    function automatic logic [HW-1:0] clamp_h(input logic [DIM_W-1:0] v);
        logic [HW-1:0] c;
        if (v < DIM_W'(MIN_DIM)) begin
            c = HW'(MIN_DIM);
        end else if (32'(v) > MAX_HEIGHT) begin
            c = HW'(MAX_HEIGHT);
        end else begin
            c = HW'(v);
        end
        return c;
    endfunction

    assign w_w       = clamp_w(r_cfg_width);
    assign w_h       = clamp_h(r_cfg_height);
    assign w_draw    = xorshift32(r_rng);
    assign w_x_last  = (WW'(r_x) + WW'(1)) == w_w;
    assign w_y_last  = (HW'(r_y) + HW'(1)) == w_h;
    assign w_read_ok = (32'(r_px) < 32'(w_w)) && (32'(r_py) < 32'(w_h));

    assign busy = (r_state != ST_IDLE) || !i_rst_n;

    // Scatter: drift and cooling of the cell read last cycle
    assign w_drift  = mod3_32(r_b_r);
    assign w_bx_inc = WW'(r_b_x) + WW'(1);

    always_comb begin
        case (w_drift)
            2'd0:    w_tx = (r_b_x == '0) ? '0 : r_b_x - XW'(1);
            2'd1:    w_tx = r_b_x;
            default: w_tx = (w_bx_inc >= w_w) ? XW'(w_w - WW'(1)) : XW'(w_bx_inc);
        endcase
    end

    always_comb begin
        if (!r_b_r[8]) begin
            w_cooled = w_rdata;
        end else if (w_rdata > r_cfg_cool) begin
            w_cooled = w_rdata - r_cfg_cool;
        end else begin
            w_cooled = '0;
        end
    end

    // Fireball scan
    assign w_reach_s  = $signed({1'b0, r_cfg_reach});
    assign w_fx       = $signed(SW'(r_px)) + SW'(r_dx);
    assign w_fy       = $signed(SW'(r_py)) + SW'(r_dy);
    assign w_dx_ext   = {{5{r_dx[4]}}, r_dx};
    assign w_dy_ext   = {{5{r_dy[4]}}, r_dy};
    assign w_dist_sq  = 10'(w_dx_ext * w_dx_ext) + 10'(w_dy_ext * w_dy_ext);
    assign w_fire_hit = (r_state == ST_FIRE)
                     && (w_fx >= 0) && (w_fx < $signed(SW'(w_w)))
                     && (w_fy >= 0) && (w_fy < $signed(SW'(w_h)))
                     && (w_dist_sq < 10'(r_cfg_rsq));

    // Write port: the phases never overlap
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_addr;
        w_wdata = '0;
        if (r_state == ST_CLEAR) begin
            w_we = 1'b1;
        end else if (r_b_valid) begin
            w_we    = 1'b1;
            w_waddr = cell_addr(w_tx, r_b_y - YW'(1));
            w_wdata = w_cooled;
        end else if (w_burn_out.valid) begin
            w_we    = 1'b1;
            w_waddr = cell_addr(XW'(w_burn_out.x), YW'(w_h - HW'(1)));
            w_wdata = w_burn_out.heat;
        end else if (w_fire_hit) begin
            w_we    = 1'b1;
            w_waddr = cell_addr(XW'(w_fx), YW'(w_fy));
            w_wdata = FULL_HEAT;
        end
    end

    always_comb begin
        if (r_state == ST_READ) begin
            w_raddr = w_read_ok ? cell_addr(XW'(r_px), YW'(r_py)) : '0;
        end else begin
            w_raddr = cell_addr(r_x, r_y);
        end
    end

    always_comb begin
        n_state    = r_state;
        n_x        = r_x;
        n_y        = r_y;
        n_addr     = r_addr;
        n_rng      = r_rng;
        n_report   = r_report;
        n_b_valid  = 1'b0;
        n_dx       = r_dx;
        n_dy       = r_dy;
        n_cmd      = r_cmd;
        n_px       = r_px;
        n_py       = r_py;
        n_done     = 1'b0;
        n_heat     = r_heat;
        n_done_cmd = r_done_cmd;
        w_burn_in  = '0;

        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_cmd = i_command;
                    n_px  = i_pos_x;
                    n_py  = i_pos_y;
                    case (i_command)
                        CMD_FRAME: begin
                            n_x     = '0;
                            n_y     = YW'(1);
                            n_state = ST_FRAME;
                        end
                        CMD_FIRE: begin
                            n_dx    = -w_reach_s;
                            n_dy    = -w_reach_s;
                            n_state = ST_FIRE;
                        end
                        CMD_READ: begin
                            n_state = ST_READ;
                        end
                        default: begin
                            n_addr   = '0;
                            n_report = 1'b1;
                            n_state  = ST_CLEAR;
                        end
                    endcase
                end
            end
            ST_CLEAR: begin
                if (r_addr == AW'(DEPTH - 1)) begin
                    n_state    = ST_IDLE;
                    n_done     = r_report;
                    n_heat     = '0;
                    n_done_cmd = r_cmd;
                end else begin
                    n_addr = r_addr + AW'(1);
                end
            end
            ST_FRAME: begin
                // one cell a cycle: read now, scatter write next cycle
                n_rng     = w_draw;
                n_b_valid = 1'b1;
                if (w_x_last) begin
                    n_x = '0;
                    if (w_y_last) begin
                        n_state = ST_FRAME_DRAIN;
                    end else begin
                        n_y = r_y + YW'(1);
                    end
                end else begin
                    n_x = r_x + XW'(1);
                end
            end
            ST_FRAME_DRAIN: begin
                n_x     = '0;
                n_state = ST_BURN;
            end
            ST_BURN: begin
                w_burn_in.valid = 1'b1;
                w_burn_in.on    = r_cfg_burner_on;
                w_burn_in.x     = COORD_W'(r_x);
                w_burn_in.r     = w_draw;
                if (r_cfg_burner_on) begin
                    n_rng = w_draw;
                end
                if (w_x_last) begin
                    n_state = ST_BURN_DRAIN;
                end else begin
                    n_x = r_x + XW'(1);
                end
            end
            ST_BURN_DRAIN: begin
                if (!w_burn_out.pending) begin
                    n_state    = ST_IDLE;
                    n_done     = 1'b1;
                    n_heat     = '0;
                    n_done_cmd = r_cmd;
                end
            end
            ST_FIRE: begin
                if (r_dx == w_reach_s) begin
                    n_dx = -w_reach_s;
                    if (r_dy == w_reach_s) begin
                        n_state    = ST_IDLE;
                        n_done     = 1'b1;
                        n_heat     = '0;
                        n_done_cmd = r_cmd;
                    end else begin
                        n_dy = r_dy + 5'sd1;
                    end
                end else begin
                    n_dx = r_dx + 5'sd1;
                end
            end
            ST_READ: begin
                n_state = ST_READ_WAIT;
            end
            ST_READ_WAIT: begin
                n_state    = ST_IDLE;
                n_done     = 1'b1;
                n_heat     = w_read_ok ? w_rdata : '0;
                n_done_cmd = r_cmd;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width     <= RST_GRID_WIDTH;
            r_cfg_height    <= RST_GRID_HEIGHT;
            r_cfg_cool      <= RST_COOLING;
            r_cfg_burner_on <= RST_BURNER_ON;
            r_cfg_gain      <= RST_BURNER_GAIN;
            r_cfg_reach     <= RST_FB_REACH;
            r_cfg_rsq       <= RST_FB_RSQ;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_GRID_WIDTH:  r_cfg_width     <= i_cfg_data[DIM_W-1:0];
                REG_GRID_HEIGHT: r_cfg_height    <= i_cfg_data[DIM_W-1:0];
                REG_COOLING:     r_cfg_cool      <= i_cfg_data[COOL_W-1:0];
                REG_BURNER_ON:   r_cfg_burner_on <= i_cfg_data[0];
                REG_BURNER_GAIN: r_cfg_gain      <= i_cfg_data[GAIN_W-1:0];
                REG_FB_REACH:    r_cfg_reach     <= i_cfg_data[REACH_W-1:0];
                REG_FB_RSQ:      r_cfg_rsq       <= i_cfg_data[RSQ_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            // sweep the store to zero, no result beat at the end
            r_state    <= ST_CLEAR;
            r_addr     <= '0;
            r_report   <= 1'b0;
            r_x        <= '0;
            r_y        <= '0;
            r_rng      <= RNG_SEED;
            r_b_valid  <= 1'b0;
            r_dx       <= '0;
            r_dy       <= '0;
            r_cmd      <= CMD_CLEAR;
            r_done     <= 1'b0;
            r_done_cmd <= CMD_FRAME;
        end else begin
            r_state    <= n_state;
            r_addr     <= n_addr;
            r_report   <= n_report;
            r_x        <= n_x;
            r_y        <= n_y;
            r_rng      <= n_rng;
            r_b_valid  <= n_b_valid;
            r_dx       <= n_dx;
            r_dy       <= n_dy;
            r_cmd      <= n_cmd;
            r_done     <= n_done;
            r_done_cmd <= n_done_cmd;
        end
        r_px   <= n_px;
        r_py   <= n_py;
        r_heat <= n_heat;
        r_b_x  <= r_x;
        r_b_y  <= r_y;
        r_b_r  <= w_draw;
    end

    assign o_done         = r_done;
    assign o_heat_value   = r_heat;
    assign o_done_command = r_done_cmd;

    ffu_ram #(
        .WIDTH (HEAT_W),
        .DEPTH (DEPTH)
    ) u_heat_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    ffu_burner u_burner (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_gain  (r_cfg_gain),
        .i_beat  (w_burn_in),
        .o_beat  (w_burn_out)
    );

    // Result beat only ever follows a working cycle
    a_done_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state != ST_IDLE))
        else $error("result beat without a command in flight");

    // Store is never written while idle
    a_no_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !w_we)
        else $error("heat store written while idle");

    // Scatter writes stay inside the frame phases
    a_scatter_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid |-> (r_state == ST_FRAME || r_state == ST_FRAME_DRAIN))
        else $error("scatter write outside frame step");

    // Burner beats only come back during the burner phases
    a_burner_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_burn_out.valid |-> (r_state == ST_BURN || r_state == ST_BURN_DRAIN))
        else $error("burner beat outside burner phase");

    // A read answers once it has passed through ST_READ and ST_READ_WAIT
    a_read_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_command == CMD_READ) |-> ##3
        (o_done && o_done_command == CMD_READ))
        else $error("read result beat late or missing");

endmodule

`default_nettype wire

>>> tb/fire_field_checker.sv
// Checker for the fire field engine: heat field predictor and result beat compare.
`timescale 1ns / 100ps

module fire_field_checker #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic                              i_busy,
    input  logic [ffu_pkg::CMD_W-1:0]         i_command,
    input  logic [ffu_pkg::POS_W-1:0]         i_pos_x,
    input  logic [ffu_pkg::POS_W-1:0]         i_pos_y,
    input  logic                              i_done,
    input  logic [ffu_pkg::HEAT_W-1:0]        i_heat_value,
    input  logic [ffu_pkg::CMD_W-1:0]         i_done_command,
    input  logic                              i_cfg_we,
    input  logic [ffu_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [ffu_pkg::CFG_DAT_W-1:0]     i_cfg_data,
    output int                                o_fail_count,
    output int                                o_outstanding
);
    import ffu_pkg::*;

    typedef struct packed {
        logic [HEAT_W-1:0] heat;
        logic [CMD_W-1:0]  cmd;
    } t_done_beat;

    t_done_beat pending_done[$];

    logic [HEAT_W-1:0]  heat_mem [MAX_WIDTH*MAX_HEIGHT];
    logic [RNG_W-1:0]   rng_q;

    logic [DIM_W-1:0]   cfg_cols;
    logic [DIM_W-1:0]   cfg_rows;
    logic [COOL_W-1:0]  cfg_cool;
    logic               cfg_burn_on;
    logic [GAIN_W-1:0]  cfg_gain;
    logic [REACH_W-1:0] cfg_reach;
    logic [RSQ_W-1:0]   cfg_rsq;

    int mismatches = 0;

    function automatic int clamped_dim(input logic [DIM_W-1:0] v, input int hi);
        if (int'(v) < MIN_DIM) return MIN_DIM;
        if (int'(v) > hi) return hi;
        return int'(v);
    endfunction

    function automatic logic [RNG_W-1:0] draw_word();
        logic [RNG_W-1:0] s;
        s = rng_q;
        s = s ^ (s << 13);
        s = s ^ (s >> 17);
        s = s ^ (s << 5);
        rng_q = s;
        return s;
    endfunction

    function automatic void wipe_field();
        foreach (heat_mem[i]) heat_mem[i] = '0;
    endfunction

    function automatic void scatter_frame();
        int w, h, x, y, tx, idx;
        logic [RNG_W-1:0]  r;
        logic [HEAT_W-1:0] v;
        logic [63:0]       u, base, hv;
        w = clamped_dim(cfg_cols, MAX_WIDTH);
        h = clamped_dim(cfg_rows, MAX_HEIGHT);
        // row y-1 was already read when row y scatters into it
        for (y = 1; y < h; y++) begin
            for (x = 0; x < w; x++) begin
                r = draw_word();
                v = heat_mem[y*MAX_WIDTH + x];
                case (r % RNG_W'(3))
                    32'd0:   tx = (x == 0) ? 0 : x - 1;
                    32'd1:   tx = x;
                    default: tx = (x + 1 >= w) ? w - 1 : x + 1;
                endcase
                if (r[8]) v = (v > cfg_cool) ? v - cfg_cool : '0;
                heat_mem[(y-1)*MAX_WIDTH + tx] = v;
            end
        end
        for (x = 0; x < w; x++) begin
            idx = (h - 1)*MAX_WIDTH + x;
            if (cfg_burn_on) begin
                u    = 64'(draw_word() & 32'h00ff_ffff);
                base = 64'(BURN_BASE) + ((64'(BURN_SPAN) * u) >> BURN_U_W);
                hv   = (base * 64'(cfg_gain)) >> GAIN_FRAC;
                heat_mem[idx] = (hv > 64'(FULL_HEAT)) ? FULL_HEAT : hv[HEAT_W-1:0];
            end else begin
                heat_mem[idx] = '0;
            end
        end
    endfunction

    function automatic void light_disc(input int cx, input int cy);
        int w, h, reach, x, y, dx, dy;
        w     = clamped_dim(cfg_cols, MAX_WIDTH);
        h     = clamped_dim(cfg_rows, MAX_HEIGHT);
        reach = int'(cfg_reach);
        for (dy = -reach; dy <= reach; dy++) begin
            y = cy + dy;
            if (y < 0 || y >= h) continue;
            for (dx = -reach; dx <= reach; dx++) begin
                x = cx + dx;
                if (x < 0 || x >= w) continue;
                if (dx*dx + dy*dy >= int'(cfg_rsq)) continue;
                heat_mem[y*MAX_WIDTH + x] = FULL_HEAT;
            end
        end
    endfunction

    function automatic t_done_beat apply_command(input logic [CMD_W-1:0] cmd,
                                                 input logic [POS_W-1:0] px,
                                                 input logic [POS_W-1:0] py);
        t_done_beat beat;
        int w, h;
        beat.heat = '0;
        beat.cmd  = cmd;
        w = clamped_dim(cfg_cols, MAX_WIDTH);
        h = clamped_dim(cfg_rows, MAX_HEIGHT);
        case (cmd)
            CMD_FRAME: scatter_frame();
            CMD_FIRE:  light_disc(int'(px), int'(py));
            CMD_READ: begin
                if (int'(px) < w && int'(py) < h)
                    beat.heat = heat_mem[int'(py)*MAX_WIDTH + int'(px)];
            end
            default:   wipe_field();
        endcase
        return beat;
    endfunction

    function automatic void write_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DAT_W-1:0] data);
        case (idx)
            REG_GRID_WIDTH:  cfg_cols    = data[DIM_W-1:0];
            REG_GRID_HEIGHT: cfg_rows    = data[DIM_W-1:0];
            REG_COOLING:     cfg_cool    = data[COOL_W-1:0];
            REG_BURNER_ON:   cfg_burn_on = data[0];
            REG_BURNER_GAIN: cfg_gain    = data[GAIN_W-1:0];
            REG_FB_REACH:    cfg_reach   = data[REACH_W-1:0];
            REG_FB_RSQ:      cfg_rsq     = data[RSQ_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic void reset_model();
        wipe_field();
        rng_q       = RNG_SEED;
        cfg_cols    = RST_GRID_WIDTH;
        cfg_rows    = RST_GRID_HEIGHT;
        cfg_cool    = RST_COOLING;
        cfg_burn_on = RST_BURNER_ON;
        cfg_gain    = RST_BURNER_GAIN;
        cfg_reach   = RST_FB_REACH;
        cfg_rsq     = RST_FB_RSQ;
    endfunction

    always @(posedge i_clk) begin : watch
        t_done_beat want, got;
        if (!i_rst_n) begin
            reset_model();
            pending_done.delete();
        end else begin
            // result beat first: it belongs to the oldest command
            if (i_done) begin
                got.heat = i_heat_value;
                got.cmd  = i_done_command;
                if (pending_done.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected result beat: cmd %0d heat %0d",
                                 $time, got.cmd, got.heat);
                end else begin
                    want = pending_done.pop_front();
                    if (want.heat !== got.heat || want.cmd !== got.cmd) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: mismatch: cmd exp %0d got %0d, heat exp %0d got %0d",
                                     $time, want.cmd, got.cmd, want.heat, got.heat);
                    end
                end
            end
            if (i_cfg_we) write_reg(i_cfg_index, i_cfg_data);
            if (i_start && !i_busy)
                pending_done.push_back(apply_command(i_command, i_pos_x, i_pos_y));
        end
        o_outstanding <= pending_done.size();
        o_fail_count  <= mismatches;
    end

endmodule

>>> tb/tb_fire_field_update_core.sv
// Testbench top: drives commands, register writes and gaps into the fire field engine.
`timescale 1ns / 100ps

module tb_fire_field_update_core;
    import ffu_pkg::*;

    localparam int MAX_W        = 256;
    localparam int MAX_H        = 256;
    localparam int CYCLE_LIMIT  = 3_000_000;
    localparam int RANDOM_ITEMS = 75;
    // index past the last register, must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    typedef struct {
        logic [DIM_W-1:0]   cols;
        logic [DIM_W-1:0]   rows;
        logic [COOL_W-1:0]  cool;
        logic               burn_on;
        logic [GAIN_W-1:0]  gain;
        logic [REACH_W-1:0] reach;
        logic [RSQ_W-1:0]   rsq;
    } t_grid_cfg;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic [CMD_W-1:0]      i_command;
    logic [POS_W-1:0]      i_pos_x;
    logic [POS_W-1:0]      i_pos_y;
    logic                  o_done;
    logic [HEAT_W-1:0]     o_heat_value;
    logic [CMD_W-1:0]      o_done_command;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DAT_W-1:0]  i_cfg_data;

    int fail_count;
    int outstanding;
    int cycle_count = 0;
    int cur_w = MAX_W;
    int cur_h = MAX_H;
    int clears_left = 2;
    bit no_idle = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    fire_field_update_core #(
        .MAX_WIDTH (MAX_W),
        .MAX_HEIGHT(MAX_H)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_command      (i_command),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .o_done         (o_done),
        .o_heat_value   (o_heat_value),
        .o_done_command (o_done_command),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    fire_field_checker #(
        .MAX_WIDTH (MAX_W),
        .MAX_HEIGHT(MAX_H)
    ) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_command      (i_command),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_done         (o_done),
        .i_heat_value   (o_heat_value),
        .i_done_command (o_done_command),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_fail_count   (fail_count),
        .o_outstanding  (outstanding)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic int clamp_dim(input logic [DIM_W-1:0] v, input int hi);
        if (int'(v) < MIN_DIM) return MIN_DIM;
        if (int'(v) > hi) return hi;
        return int'(v);
    endfunction

    // random filler above the register's own bits
    function automatic logic [CFG_DAT_W-1:0] pad_junk(input logic [CFG_DAT_W-1:0] v,
                                                      input int bits);
        logic [CFG_DAT_W-1:0] mask;
        mask = CFG_DAT_W'((32'd1 << bits) - 1);
        return (v & mask) | (CFG_DAT_W'($urandom) & ~mask);
    endfunction

    function automatic int pick_gap();
        int k;
        k = $urandom_range(0, 99);
        if (k < 40) return 0;
        if (k < 85) return $urandom_range(1, 3);
        if (k < 96) return $urandom_range(4, 20);
        return $urandom_range(50, 300);
    endfunction

    // mostly small grids keep frame steps short; either dimension or both may go out of range
    function automatic t_grid_cfg random_cfg();
        t_grid_cfg c;
        case ($urandom_range(0, 9))
            0: begin
                c.cols = DIM_W'($urandom_range(256, 511));
                c.rows = DIM_W'($urandom_range(0, 16));
            end
            1: begin
                c.cols = DIM_W'($urandom_range(0, 16));
                c.rows = DIM_W'($urandom_range(256, 511));
            end
            2: begin
                c.cols = DIM_W'($urandom_range(0, 7));
                c.rows = DIM_W'($urandom_range(8, 40));
            end
            default: begin
                c.cols = DIM_W'($urandom_range(8, 48));
                c.rows = DIM_W'($urandom_range(8, 48));
            end
        endcase
        case ($urandom_range(0, 7))
            0:       c.cool = '0;
            1:       c.cool = '1;
            2:       c.cool = COOL_W'($urandom);
            default: c.cool = COOL_W'($urandom_range(0, 3000));
        endcase
        c.burn_on = ($urandom_range(0, 3) != 0);
        c.gain    = ($urandom_range(0, 4) == 0) ? GAIN_W'($urandom)
                                                : GAIN_W'($urandom_range(16384, 18022));
        c.reach   = REACH_W'($urandom);
        c.rsq     = RSQ_W'($urandom);
        return c;
    endfunction

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DAT_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
    endtask

    task automatic apply_config(input t_grid_cfg c);
        cfg_write(REG_UNUSED,      CFG_DAT_W'($urandom));
        cfg_write(REG_GRID_WIDTH,  pad_junk(CFG_DAT_W'(c.cols), DIM_W));
        cfg_write(REG_GRID_HEIGHT, pad_junk(CFG_DAT_W'(c.rows), DIM_W));
        cfg_write(REG_COOLING,     c.cool);
        cfg_write(REG_BURNER_ON,   pad_junk(CFG_DAT_W'(c.burn_on), 1));
        cfg_write(REG_BURNER_GAIN, pad_junk(CFG_DAT_W'(c.gain), GAIN_W));
        cfg_write(REG_FB_REACH,    pad_junk(CFG_DAT_W'(c.reach), REACH_W));
        cfg_write(REG_FB_RSQ,      pad_junk(CFG_DAT_W'(c.rsq), RSQ_W));
        i_cfg_we <= 1'b0;
        cur_w = clamp_dim(c.cols, MAX_W);
        cur_h = clamp_dim(c.rows, MAX_H);
    endtask

    // command beat: held until taken, start left high afterwards unless a gap follows
    task automatic send(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] x,
                        input logic [POS_W-1:0] y);
        int n;
        start     <= 1'b1;
        i_command <= cmd;
        i_pos_x   <= x;
        i_pos_y   <= y;
        do @(posedge i_clk); while (busy);
        n = no_idle ? 0 : pick_gap();
        if (n > 0) begin
            start     <= 1'b0;
            i_command <= CMD_W'($urandom);
            i_pos_x   <= POS_W'($urandom);
            i_pos_y   <= POS_W'($urandom);
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
        while (busy) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic random_item();
        int sel;
        sel = $urandom_range(0, 99);
        if (clears_left > 0 && sel == 0) begin
            clears_left--;
            send(CMD_CLEAR, POS_W'($urandom), POS_W'($urandom));
        end else if (sel < 25) begin
            if ($urandom_range(0, 4) != 0)
                send(CMD_FIRE, POS_W'($urandom_range(0, cur_w - 1)),
                     POS_W'($urandom_range(0, cur_h - 1)));
            else
                send(CMD_FIRE, POS_W'($urandom), POS_W'($urandom));
        end else if (sel < 52) begin
            send(CMD_FRAME, POS_W'($urandom), POS_W'($urandom));
        end else begin
            if ($urandom_range(0, 3) != 0)
                send(CMD_READ, POS_W'($urandom_range(0, cur_w - 1)),
                     POS_W'($urandom_range(0, cur_h - 1)));
            else
                send(CMD_READ, POS_W'($urandom), POS_W'($urandom));
        end
    endtask

    initial begin : stimulus
        int rand_items;
        int n;
        rand_items  = 0;
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_command   <= CMD_FRAME;
        i_pos_x     <= '0;
        i_pos_y     <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= REG_GRID_WIDTH;
        i_cfg_data  <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // full-size grid at reset settings; fireball runs off the bottom edge
        send(CMD_FIRE, 8'd128, 8'd250);
        send(CMD_FRAME, 8'd0, 8'd0);
        send(CMD_READ, 8'd128, 8'd249);
        send(CMD_READ, 8'd128, 8'd248);
        send(CMD_READ, 8'd255, 8'd255);
        send(CMD_READ, 8'd0, 8'd0);

        // smallest grid, widest disc, no cooling, raised gain
        drain();
        apply_config('{cols: 9'd8, rows: 9'd8, cool: 16'd0, burn_on: 1'b1,
                       gain: 15'd18022, reach: 4'd15, rsq: 8'd255});
        send(CMD_FIRE, 8'd0, 8'd0);
        send(CMD_FIRE, 8'd255, 8'd255);
        send(CMD_FRAME, 8'hff, 8'hff);
        send(CMD_READ, 8'd7, 8'd7);
        send(CMD_READ, 8'd0, 8'd6);
        send(CMD_READ, 8'd8, 8'd0);
        send(CMD_READ, 8'd0, 8'd8);
        send(CMD_READ, 8'd7, 8'd6);

        // sizes out of range clamp; full cooling, burner off, single-cell disc
        drain();
        apply_config('{cols: 9'd5, rows: 9'd511, cool: 16'hffff, burn_on: 1'b0,
                       gain: 15'h7fff, reach: 4'd0, rsq: 8'd1});
        send(CMD_FIRE, 8'd3, 8'd100);
        send(CMD_READ, 8'd3, 8'd100);
        send(CMD_FRAME, 8'd0, 8'd0);
        send(CMD_READ, 8'd3, 8'd99);
        send(CMD_READ, 8'd3, 8'd255);

        // empty disc, clear, then burner refill
        drain();
        apply_config('{cols: 9'd16, rows: 9'd12, cool: 16'd922, burn_on: 1'b1,
                       gain: 15'd16384, reach: 4'd0, rsq: 8'd0});
        send(CMD_FIRE, 8'd5, 8'd5);
        send(CMD_READ, 8'd5, 8'd5);
        send(CMD_CLEAR, 8'd0, 8'd0);
        send(CMD_READ, 8'd3, 8'd11);
        send(CMD_FRAME, 8'd0, 8'd0);
        send(CMD_READ, 8'd3, 8'd11);

        while (rand_items < RANDOM_ITEMS) begin
            drain();
            apply_config(random_cfg());
            no_idle = ($urandom_range(0, 3) == 0);
            send(CMD_FIRE, POS_W'($urandom_range(0, cur_w - 1)),
                 POS_W'($urandom_range(0, cur_h - 1)));
            rand_items++;
            n = $urandom_range(5, 12);
            repeat (n) begin
                random_item();
                rand_items++;
            end
        end

        drain();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
